// File: src/rdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg: shared types and constants for the relay drive controller
// Item structs, configuration set, mode encoding and register indexes.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_FORWARD_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_THRESHOLD = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_DISTANCE     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ANTI_PLUG_DELAY   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UPDATE_PERIOD     = 3'd4;

  localparam logic [9:0]  RESET_FORWARD_THRESHOLD = 10'd600;
  localparam logic [9:0]  RESET_REVERSE_THRESHOLD = 10'd400;
  localparam logic [9:0]  RESET_STOP_DISTANCE     = 10'd30;
  localparam logic [15:0] RESET_ANTI_PLUG_DELAY   = 16'd1000;
  localparam logic [15:0] RESET_UPDATE_PERIOD     = 16'd50;

  localparam logic [2:0] MODE_CODE_START    = 3'd0;
  localparam logic [2:0] MODE_CODE_STOPPED  = 3'd1;
  localparam logic [2:0] MODE_CODE_FORWARD  = 3'd2;
  localparam logic [2:0] MODE_CODE_REVERSE  = 3'd3;
  localparam logic [2:0] MODE_CODE_BEGIN_AP = 3'd4;
  localparam logic [2:0] MODE_CODE_AP       = 3'd5;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [9:0]  joystick_position;
    logic [9:0]  front_distance;
    logic [9:0]  rear_distance;
  } in_item_t;

  typedef struct packed {
    logic       forward_on;
    logic       reverse_on;
    logic [2:0] mode_code;
    logic [9:0] nearest_distance;
    logic       acted;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  forward_threshold;
    logic [9:0]  reverse_threshold;
    logic [9:0]  stop_distance;
    logic [15:0] anti_plug_delay_ms;
    logic [15:0] update_period_ms;
  } cfg_t;

  typedef enum logic [1:0] {
    JOY_MID = 2'd0,
    JOY_FWD = 2'd1,
    JOY_REV = 2'd2
  } joy_class_t;

  typedef enum logic [1:0] {
    OBS_CLEAR = 2'd0,
    OBS_FRONT = 2'd1,
    OBS_BACK  = 2'd2
  } obs_class_t;

  typedef struct packed {
    logic [31:0] now_ms;
    joy_class_t  joy;
    obs_class_t  obs;
    logic [9:0]  nearest;
  } class_item_t;

  typedef enum logic [5:0] {
    MODE_START    = 6'b000001,
    MODE_STOPPED  = 6'b000010,
    MODE_FORWARD  = 6'b000100,
    MODE_REVERSE  = 6'b001000,
    MODE_BEGIN_AP = 6'b010000,
    MODE_AP       = 6'b100000
  } mode_t;

  function automatic logic [2:0] mode_to_code(mode_t m);
    logic [2:0] code;
    unique case (m)
      MODE_STOPPED:  code = MODE_CODE_STOPPED;
      MODE_FORWARD:  code = MODE_CODE_FORWARD;
      MODE_REVERSE:  code = MODE_CODE_REVERSE;
      MODE_BEGIN_AP: code = MODE_CODE_BEGIN_AP;
      MODE_AP:       code = MODE_CODE_AP;
      default:       code = MODE_CODE_START;
    endcase
    return code;
  endfunction

endpackage

// File: src/rdc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_front: input classifier
// Sorts the joystick into high, low or mid and the obstacle into front, back
// or clear, and picks the nearer distance.
// ----------------------------------------------------------------------------
module rdc_front import rdc_pkg::*; (
  input  cfg_t        cfg,
  input  in_item_t    item,
  output class_item_t cls
);

  always_comb begin
    cls.now_ms = item.now_ms;

    // high wins over low when the thresholds cross
    if (item.joystick_position > cfg.forward_threshold) begin
      cls.joy = JOY_FWD;
    end else if (item.joystick_position < cfg.reverse_threshold) begin
      cls.joy = JOY_REV;
    end else begin
      cls.joy = JOY_MID;
    end

    if (item.front_distance <= cfg.stop_distance) begin
      cls.obs = OBS_FRONT;
    end else if (item.rear_distance <= cfg.stop_distance) begin
      cls.obs = OBS_BACK;
    end else begin
      cls.obs = OBS_CLEAR;
    end

    cls.nearest = (item.front_distance <= item.rear_distance) ?
                  item.front_distance : item.rear_distance;
  end

endmodule

// File: src/rdc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_queue: classified item queue
// Small register FIFO that decouples the classifier from the state machine.
// ----------------------------------------------------------------------------
module rdc_queue import rdc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_stall,
  input  class_item_t push_data,
  output logic        pop_valid,
  input  logic        pop_stall,
  output class_item_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  class_item_t       entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_stall = (count == CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/rdc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_back: relay state machine
// Applies the update gate, advances the six-state mode machine with the
// anti-plugging stop, drives the relays and registers the result.
// ----------------------------------------------------------------------------
module rdc_back import rdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        item_valid,
  output logic        item_stall,
  input  class_item_t item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  mode_t       mode;
  mode_t       mode_next;
  logic [31:0] last_update_time;
  logic [31:0] plug_start_time;
  logic        forward_relay;
  logic        reverse_relay;
  logic        forward_relay_next;
  logic        reverse_relay_next;
  logic        gate;
  logic        expired;
  logic        take;
  logic [31:0] since_update;
  logic [31:0] since_plug;

  assign item_stall   = out_valid && out_stall;
  assign take         = item_valid && !item_stall;
  assign since_update = item.now_ms - last_update_time;
  assign since_plug   = item.now_ms - plug_start_time;
  assign gate         = since_update >= {16'd0, cfg.update_period_ms};
  assign expired      = since_plug > {16'd0, cfg.anti_plug_delay_ms};

  always_comb begin
    mode_next = mode;
    if (gate) begin
      unique case (mode)
        MODE_STOPPED: begin
          if (item.joy == JOY_FWD && item.obs != OBS_FRONT) begin
            mode_next = MODE_FORWARD;
          end else if (item.joy == JOY_REV && item.obs != OBS_BACK) begin
            mode_next = MODE_REVERSE;
          end
        end
        MODE_FORWARD: begin
          if (item.joy == JOY_REV) begin
            mode_next = MODE_BEGIN_AP;
          end else if (item.joy == JOY_MID || item.obs == OBS_FRONT) begin
            mode_next = MODE_STOPPED;
          end
        end
        MODE_REVERSE: begin
          if (item.joy == JOY_FWD) begin
            mode_next = MODE_BEGIN_AP;
          end else if (item.joy == JOY_MID || item.obs == OBS_BACK) begin
            mode_next = MODE_STOPPED;
          end
        end
        MODE_BEGIN_AP: begin
          mode_next = MODE_AP;
        end
        MODE_AP: begin
          if (item.joy == JOY_REV && expired && item.obs != OBS_BACK) begin
            mode_next = MODE_REVERSE;
          end else if (item.joy == JOY_FWD && expired && item.obs != OBS_FRONT) begin
            mode_next = MODE_FORWARD;
          end
        end
        default: begin
          mode_next = MODE_STOPPED;
        end
      endcase
    end
  end

  // begin-antiplug keeps the previous drive for one acted item
  always_comb begin
    forward_relay_next = forward_relay;
    reverse_relay_next = reverse_relay;
    if (gate) begin
      case (mode_next)
        MODE_STOPPED, MODE_AP: begin
          forward_relay_next = 1'b0;
          reverse_relay_next = 1'b0;
        end
        MODE_FORWARD: begin
          forward_relay_next = 1'b1;
          reverse_relay_next = 1'b0;
        end
        MODE_REVERSE: begin
          forward_relay_next = 1'b0;
          reverse_relay_next = 1'b1;
        end
        default: begin
          forward_relay_next = forward_relay;
          reverse_relay_next = reverse_relay;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_START;
      last_update_time <= '0;
      plug_start_time  <= '0;
      forward_relay    <= 1'b0;
      reverse_relay    <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (take) begin
        mode          <= mode_next;
        forward_relay <= forward_relay_next;
        reverse_relay <= reverse_relay_next;
        if (gate) begin
          last_update_time <= item.now_ms;
        end
        if (gate && mode_next == MODE_BEGIN_AP) begin
          plug_start_time <= item.now_ms;
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.forward_on       <= forward_relay_next;
      out_data.reverse_on       <= reverse_relay_next;
      out_data.mode_code        <= mode_to_code(mode_next);
      out_data.nearest_distance <= item.nearest;
      out_data.acted            <= gate;
    end
  end

endmodule

// File: src/relay_drive_controller_with_antiplug.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_drive_controller_with_antiplug: joystick relay drive with anti-plug
// Classifier front end, item queue and relay state machine back end.
// ----------------------------------------------------------------------------
// Path: each accepted item is classified, held in the queue, then registered by the back end.
// Throughput: one item per cycle while out_stall is low; the mode and timestamp update in
// the back end is registered as each item is taken, and the queue holds items during output stalls.
// Reset (rst, synchronous): mode start, times zero, relays off, queue empty,
// registers at their default values.
// ----------------------------------------------------------------------------
module relay_drive_controller_with_antiplug import rdc_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t        cfg;
  class_item_t front_cls;
  class_item_t q_data;
  logic        q_valid;
  logic        q_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.forward_threshold  <= RESET_FORWARD_THRESHOLD;
      cfg.reverse_threshold  <= RESET_REVERSE_THRESHOLD;
      cfg.stop_distance      <= RESET_STOP_DISTANCE;
      cfg.anti_plug_delay_ms <= RESET_ANTI_PLUG_DELAY;
      cfg.update_period_ms   <= RESET_UPDATE_PERIOD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FORWARD_THRESHOLD: cfg.forward_threshold  <= cfg_data[9:0];
        CFG_REVERSE_THRESHOLD: cfg.reverse_threshold  <= cfg_data[9:0];
        CFG_STOP_DISTANCE:     cfg.stop_distance      <= cfg_data[9:0];
        CFG_ANTI_PLUG_DELAY:   cfg.anti_plug_delay_ms <= cfg_data;
        CFG_UPDATE_PERIOD:     cfg.update_period_ms   <= cfg_data;
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  rdc_front u_front (
    .cfg  (cfg),
    .item (in_data),
    .cls  (front_cls)
  );

  rdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_data  (front_cls),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_data   (q_data)
  );

  rdc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (q_valid),
    .item_stall (q_stall),
    .item       (q_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  a_relays_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.forward_on && out_data.reverse_on))
    else $error("forward and reverse relays both driven");

  a_forward_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.forward_on) |->
      (out_data.mode_code == MODE_CODE_FORWARD ||
       out_data.mode_code == MODE_CODE_BEGIN_AP))
    else $error("forward relay driven outside forward travel");

  a_reverse_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.reverse_on) |->
      (out_data.mode_code == MODE_CODE_REVERSE ||
       out_data.mode_code == MODE_CODE_BEGIN_AP))
    else $error("reverse relay driven outside reverse travel");

  a_stop_relays_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.mode_code == MODE_CODE_STOPPED ||
                   out_data.mode_code == MODE_CODE_AP)) |->
      (!out_data.forward_on && !out_data.reverse_on))
    else $error("relay driven while stopped");

endmodule

// File: verif/relay_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_drive_checker: result predictor and comparator for the relay drive
// Watches the item, result and register ports, keeps its own copy of the
// drive state machine and settings, and compares every result transfer with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module relay_drive_checker import rdc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  out_item_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending_count
);

  localparam int REPORT_LIMIT = 10;

  cfg_t        cfg_shadow;
  logic [2:0]  drive_mode;
  logic [31:0] last_acted_ms;
  logic [31:0] plug_start_ms;
  logic        fwd_relay;
  logic        rev_relay;
  out_item_t   expected_relay_q[$];
  int          failures = 0;

  function automatic joy_class_t classify_stick(logic [9:0] pos);
    if (pos > cfg_shadow.forward_threshold) return JOY_FWD;
    if (pos < cfg_shadow.reverse_threshold) return JOY_REV;
    return JOY_MID;
  endfunction

  // Front obstacle wins when both sides are blocked
  function automatic obs_class_t classify_path(logic [9:0] front, logic [9:0] rear);
    if (front <= cfg_shadow.stop_distance) return OBS_FRONT;
    if (rear <= cfg_shadow.stop_distance) return OBS_BACK;
    return OBS_CLEAR;
  endfunction

  function automatic out_item_t predict_relay_result(in_item_t item);
    out_item_t   res;
    joy_class_t  stick;
    obs_class_t  path;
    logic [31:0] since_update;
    logic [31:0] since_plug;
    logic        expired;
    res = '0;
    since_update = item.now_ms - last_acted_ms;
    since_plug = item.now_ms - plug_start_ms;
    res.nearest_distance = (item.front_distance <= item.rear_distance) ?
                           item.front_distance : item.rear_distance;
    if (since_update >= {16'd0, cfg_shadow.update_period_ms}) begin
      stick = classify_stick(item.joystick_position);
      path = classify_path(item.front_distance, item.rear_distance);
      expired = since_plug > {16'd0, cfg_shadow.anti_plug_delay_ms};
      res.acted = 1'b1;
      last_acted_ms = item.now_ms;
      case (drive_mode)
        MODE_CODE_STOPPED: begin
          if (stick == JOY_FWD && path != OBS_FRONT) drive_mode = MODE_CODE_FORWARD;
          else if (stick == JOY_REV && path != OBS_BACK) drive_mode = MODE_CODE_REVERSE;
        end
        MODE_CODE_FORWARD: begin
          if (stick == JOY_REV) drive_mode = MODE_CODE_BEGIN_AP;
          else if (stick == JOY_MID || path == OBS_FRONT) drive_mode = MODE_CODE_STOPPED;
        end
        MODE_CODE_REVERSE: begin
          if (stick == JOY_FWD) drive_mode = MODE_CODE_BEGIN_AP;
          else if (stick == JOY_MID || path == OBS_BACK) drive_mode = MODE_CODE_STOPPED;
        end
        MODE_CODE_BEGIN_AP: drive_mode = MODE_CODE_AP;
        MODE_CODE_AP: begin
          if (stick == JOY_REV && expired && path != OBS_BACK) drive_mode = MODE_CODE_REVERSE;
          else if (stick == JOY_FWD && expired && path != OBS_FRONT)
            drive_mode = MODE_CODE_FORWARD;
        end
        default: drive_mode = MODE_CODE_STOPPED;
      endcase
      // Relays hold their drive through the begin anti-plug step
      case (drive_mode)
        MODE_CODE_STOPPED, MODE_CODE_AP: begin
          fwd_relay = 1'b0;
          rev_relay = 1'b0;
        end
        MODE_CODE_FORWARD: begin
          fwd_relay = 1'b1;
          rev_relay = 1'b0;
        end
        MODE_CODE_REVERSE: begin
          fwd_relay = 1'b0;
          rev_relay = 1'b1;
        end
        MODE_CODE_BEGIN_AP: plug_start_ms = item.now_ms;
        default: ;
      endcase
    end
    res.forward_on = fwd_relay;
    res.reverse_on = rev_relay;
    res.mode_code = drive_mode;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      cfg_shadow.forward_threshold = RESET_FORWARD_THRESHOLD;
      cfg_shadow.reverse_threshold = RESET_REVERSE_THRESHOLD;
      cfg_shadow.stop_distance = RESET_STOP_DISTANCE;
      cfg_shadow.anti_plug_delay_ms = RESET_ANTI_PLUG_DELAY;
      cfg_shadow.update_period_ms = RESET_UPDATE_PERIOD;
      drive_mode = MODE_CODE_START;
      last_acted_ms = '0;
      plug_start_ms = '0;
      fwd_relay = 1'b0;
      rev_relay = 1'b0;
      expected_relay_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FORWARD_THRESHOLD: cfg_shadow.forward_threshold = cfg_data[9:0];
          CFG_REVERSE_THRESHOLD: cfg_shadow.reverse_threshold = cfg_data[9:0];
          CFG_STOP_DISTANCE:     cfg_shadow.stop_distance = cfg_data[9:0];
          CFG_ANTI_PLUG_DELAY:   cfg_shadow.anti_plug_delay_ms = cfg_data;
          CFG_UPDATE_PERIOD:     cfg_shadow.update_period_ms = cfg_data;
          default: ;
        endcase
      end
      // Compare before predicting: a result never belongs to this edge's item
      if (out_valid && !out_stall) begin
        if (expected_relay_q.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("unexpected relay result: fwd=%0b rev=%0b mode=%0d near=%0d acted=%0b",
                     out_data.forward_on, out_data.reverse_on, out_data.mode_code,
                     out_data.nearest_distance, out_data.acted);
        end else begin
          want = expected_relay_q.pop_front();
          if (out_data.forward_on !== want.forward_on ||
              out_data.reverse_on !== want.reverse_on ||
              out_data.mode_code !== want.mode_code ||
              out_data.nearest_distance !== want.nearest_distance ||
              out_data.acted !== want.acted) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("relay mismatch expected: fwd=%0b rev=%0b mode=%0d near=%0d acted=%0b",
                       want.forward_on, want.reverse_on, want.mode_code,
                       want.nearest_distance, want.acted);
              $display("relay mismatch got:      fwd=%0b rev=%0b mode=%0d near=%0d acted=%0b",
                       out_data.forward_on, out_data.reverse_on, out_data.mode_code,
                       out_data.nearest_distance, out_data.acted);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        expected_relay_q.push_back(predict_relay_result(in_data));
    end
    fail_count <= failures;
    pending_count <= expected_relay_q.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the relay drive controller
// Directed walk through the drive states and timing edges, then random
// timestamped samples over several register settings with random input
// gaps and output stalls; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb;
  import rdc_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int HOLD_OFF_CYCLES  = 80;
  localparam int SETTLE_CYCLES    = 4;
  localparam int PHASE_COUNT      = 7;
  localparam int ITEMS_PER_PHASE  = 180;
  localparam int ITEMS_FROZEN     = 60;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_UNMAPPED = 3'd7;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_data;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending_count;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          cycle_count = 0;
  logic [31:0] sim_ms = '0;
  cfg_t        cur_cfg;
  cfg_t        phase_cfg;

  relay_drive_controller_with_antiplug u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  relay_drive_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic offer_item(input logic [31:0] now, input logic [9:0] joy,
                            input logic [9:0] front, input logic [9:0] rear);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{now, joy, front, rear};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic write_settings(input cfg_t s);
    put_reg(CFG_FORWARD_THRESHOLD, {6'd0, s.forward_threshold});
    put_reg(CFG_REVERSE_THRESHOLD, {6'd0, s.reverse_threshold});
    put_reg(CFG_STOP_DISTANCE, {6'd0, s.stop_distance});
    put_reg(CFG_ANTI_PLUG_DELAY, s.anti_plug_delay_ms);
    put_reg(CFG_UPDATE_PERIOD, s.update_period_ms);
    // Unmapped index must leave every register alone
    put_reg(CFG_INDEX_UNMAPPED, CFG_DATA_W'($urandom()));
    cfg_write <= 1'b0;
    cur_cfg = s;
  endtask

  function automatic cfg_t random_settings(bit full_range);
    cfg_t s;
    if (full_range) begin
      s.forward_threshold = 10'($urandom_range(0, 1023));
      s.reverse_threshold = 10'($urandom_range(0, 1023));
      s.stop_distance = 10'($urandom_range(0, 1023));
      s.anti_plug_delay_ms = 16'($urandom_range(0, 65535));
      s.update_period_ms = 16'($urandom_range(0, 65535));
    end else begin
      s.forward_threshold = 10'($urandom_range(500, 1000));
      s.reverse_threshold = 10'($urandom_range(20, 500));
      s.stop_distance = 10'($urandom_range(0, 150));
      s.anti_plug_delay_ms = 16'($urandom_range(0, 400));
      s.update_period_ms = 16'($urandom_range(0, 40));
    end
    return s;
  endfunction

  // Aim mostly at a chosen joystick class so the machine keeps moving
  function automatic logic [9:0] pick_joystick();
    int dice;
    dice = $urandom_range(0, 99);
    if (dice < 35 && cur_cfg.forward_threshold != 10'd1023)
      return 10'($urandom_range(cur_cfg.forward_threshold + 1, 1023));
    if (dice < 70 && cur_cfg.reverse_threshold != 10'd0)
      return 10'($urandom_range(0, cur_cfg.reverse_threshold - 1));
    if (dice < 85 && cur_cfg.reverse_threshold <= cur_cfg.forward_threshold)
      return 10'($urandom_range(cur_cfg.reverse_threshold, cur_cfg.forward_threshold));
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic logic [9:0] pick_distance();
    int dice;
    dice = $urandom_range(0, 99);
    if (dice < 15 || cur_cfg.stop_distance == 10'd1023)
      return 10'($urandom_range(0, cur_cfg.stop_distance));
    if (dice < 25)
      return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(cur_cfg.stop_distance + 1, 1023));
  endfunction

  task automatic advance_clock_ms();
    int          dice;
    logic [31:0] period;
    logic [31:0] delay;
    dice = $urandom_range(0, 99);
    period = {16'd0, cur_cfg.update_period_ms};
    delay = {16'd0, cur_cfg.anti_plug_delay_ms};
    if (dice < 65) sim_ms = sim_ms + period + $urandom_range(0, period / 4 + 2);
    else if (dice < 80) sim_ms = sim_ms + $urandom_range(0, period);
    else if (dice < 95) sim_ms = sim_ms + $urandom_range(delay / 4, delay / 2 + 2);
    else sim_ms = $urandom();
  endtask

  initial begin : stimulus
    int phase;
    int count;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_cfg = '{RESET_FORWARD_THRESHOLD, RESET_REVERSE_THRESHOLD, RESET_STOP_DISTANCE,
                RESET_ANTI_PLUG_DELAY, RESET_UPDATE_PERIOD};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed walk on the reset settings
    offer_item(32'd0, 10'd1023, 10'd0, 10'd1023);       // gated out at time zero
    offer_item(32'd50, 10'd512, 10'd1023, 10'd1023);    // start to stopped, exact period
    offer_item(32'd100, 10'd601, 10'd30, 10'd1023);     // front obstacle at stop distance
    offer_item(32'd150, 10'd601, 10'd31, 10'd30);       // forward despite rear obstacle
    offer_item(32'd199, 10'd0, 10'd500, 10'd500);       // one short of the period
    offer_item(32'd200, 10'd600, 10'd500, 10'd500);     // threshold itself is mid
    offer_item(32'd250, 10'd399, 10'd0, 10'd0);         // both blocked: front wins
    offer_item(32'd300, 10'd1023, 10'd500, 10'd500);    // reverse to begin anti-plug
    offer_item(32'd350, 10'd0, 10'd500, 10'd500);
    offer_item(32'd1300, 10'd0, 10'd500, 10'd500);      // delay reached, not exceeded
    offer_item(32'd1350, 10'd0, 10'd500, 10'd0);        // expired but rear blocked
    offer_item(32'd1400, 10'd0, 10'd500, 10'd500);
    offer_item(32'd1450, 10'd400, 10'd500, 10'd500);
    offer_item(32'd1500, 10'd700, 10'd500, 10'd500);
    offer_item(32'd1550, 10'd700, 10'd10, 10'd500);     // forward stops on front obstacle
    offer_item(32'd1600, 10'd700, 10'd500, 10'd500);
    offer_item(32'd1650, 10'd100, 10'd500, 10'd500);    // forward to begin anti-plug
    offer_item(32'd1700, 10'd900, 10'd500, 10'd500);
    offer_item(32'd2651, 10'd900, 10'd5, 10'd500);      // expired but front blocked
    offer_item(32'd2700, 10'd900, 10'd500, 10'd500);
    offer_item(32'hFFFF_FFF0, 10'd900, 10'd1023, 10'd1023);
    offer_item(32'h0000_0010, 10'd900, 10'd1023, 10'd1023); // wrapped, still too soon
    offer_item(32'h0000_0022, 10'd0, 10'd1023, 10'd1023);   // wrapped, exact period
    offer_item(32'h0000_0050, 10'd0, 10'd1023, 10'd1023);
    sim_ms = 32'h0000_0100;

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_drained();
      case (phase)
        0: phase_cfg = '{RESET_FORWARD_THRESHOLD, RESET_REVERSE_THRESHOLD, RESET_STOP_DISTANCE,
                         RESET_ANTI_PLUG_DELAY, RESET_UPDATE_PERIOD};
        1: phase_cfg = '{10'd0, 10'd1023, 10'd0, 16'hFFFF, 16'hFFFF};
        3: phase_cfg = '{10'd1023, 10'd0, 10'd1023, 16'd0, 16'd0};
        5: phase_cfg = random_settings(1'b1);
        default: phase_cfg = random_settings(1'b0);
      endcase
      write_settings(phase_cfg);
      if (phase < 2) begin
        send_idle_pct = 32;
        recv_idle_pct = 70;
      end else if (phase < 4) begin
        send_idle_pct = 70;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Long receiver hold-off while items keep coming: fill the block
      if (phase == 0 || phase == 4) hold_requests = hold_requests + 1;
      count = (phase == 3) ? ITEMS_FROZEN : ITEMS_PER_PHASE;
      for (int n = 0; n < count; n++) begin
        advance_clock_ms();
        offer_item(sim_ms, pick_joystick(), pick_distance(), pick_distance());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
